[rtl/ntc_pkg.sv]
// ntc_pkg: shared types, constants and the symbol lookup for the nibble text compressor
// no dependencies; imported by every module of the block

package ntc_pkg;

    // coding constants
    localparam int unsigned NTC_SHORT_CODES     = 13;
    localparam int unsigned NTC_LONG_OFFSET     = 195;
    localparam int unsigned NTC_MAX_CHARS_RESET = 80;
    localparam int unsigned NTC_QUEUE_DEPTH     = 4;

    // configuration port
    localparam int unsigned NTC_ADDR_W = 3;
    localparam int unsigned NTC_DATA_W = 32;
    localparam logic        NTC_REG_MAX_CHARS = 1'b0;  // word index of max_chars

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic [7:0] bytes_so_far;
    } ntc_res_t;

    // work for the back end: one or two result beats
    typedef struct packed {
        logic     two;
        ntc_res_t r0;
        ntc_res_t r1;
    } ntc_job_t;

    // front state seen by the top level checks
    typedef struct packed {
        logic       nibble_pending;
        logic [7:0] chars_taken;
    } ntc_front_status_t;

    // lower-case the byte and find its place in the frequency table; unknown codes as space
    function automatic logic [5:0] ntc_lookup(input logic [7:0] c);
        logic [7:0] lc;
        logic [5:0] idx;
        lc = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            lc = c + 8'd32;
        end
        unique case (lc)
            8'h20: idx = 6'd0;
            8'h65: idx = 6'd1;
            8'h74: idx = 6'd2;
            8'h61: idx = 6'd3;
            8'h6f: idx = 6'd4;
            8'h69: idx = 6'd5;
            8'h68: idx = 6'd6;
            8'h6e: idx = 6'd7;
            8'h73: idx = 6'd8;
            8'h72: idx = 6'd9;
            8'h64: idx = 6'd10;
            8'h6c: idx = 6'd11;
            8'h75: idx = 6'd12;
            8'h6d: idx = 6'd13;
            8'h77: idx = 6'd14;
            8'h63: idx = 6'd15;
            8'h79: idx = 6'd16;
            8'h66: idx = 6'd17;
            8'h67: idx = 6'd18;
            8'h70: idx = 6'd19;
            8'h62: idx = 6'd20;
            8'h76: idx = 6'd21;
            8'h6b: idx = 6'd22;
            8'h78: idx = 6'd23;
            8'h6a: idx = 6'd24;
            8'h71: idx = 6'd25;
            8'h7a: idx = 6'd26;
            8'h30: idx = 6'd27;
            8'h31: idx = 6'd28;
            8'h32: idx = 6'd29;
            8'h33: idx = 6'd30;
            8'h34: idx = 6'd31;
            8'h35: idx = 6'd32;
            8'h36: idx = 6'd33;
            8'h37: idx = 6'd34;
            8'h38: idx = 6'd35;
            8'h39: idx = 6'd36;
            8'h21: idx = 6'd38;
            8'h3f: idx = 6'd39;
            8'h2e: idx = 6'd40;
            8'h2c: idx = 6'd41;
            8'h3a: idx = 6'd42;
            8'h3b: idx = 6'd43;
            8'h28: idx = 6'd44;
            8'h29: idx = 6'd45;
            8'h2d: idx = 6'd46;
            8'h26: idx = 6'd47;
            8'h2a: idx = 6'd48;
            8'h5c: idx = 6'd49;
            8'h27: idx = 6'd50;
            8'h40: idx = 6'd51;
            8'h23: idx = 6'd52;
            8'h2b: idx = 6'd53;
            8'h3d: idx = 6'd54;
            8'ha3: idx = 6'd55;
            8'h24: idx = 6'd56;
            8'h25: idx = 6'd57;
            8'h22: idx = 6'd58;
            8'h5b: idx = 6'd59;
            8'h5d: idx = 6'd60;
            default: idx = 6'd0;
        endcase
        return idx;
    endfunction

endpackage

[rtl/ntc_front.sv]
// ntc_front: takes one character a beat, codes it and builds the result job
// depends on ntc_pkg

module ntc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 max_chars,
    input  logic                       take,
    input  logic [7:0]                 char_code,
    input  logic                       msg_last,
    output logic                       job_valid,
    output ntc_pkg::ntc_job_t          job,
    output ntc_pkg::ntc_front_status_t status
);
    import ntc_pkg::*;

    logic       pending_reg, pending_next;
    logic [3:0] held_reg, held_next;
    logic [7:0] chars_taken_reg, chars_taken_next;
    logic [7:0] bytes_emitted_reg, bytes_emitted_next;

    logic       coded;
    logic [5:0] idx;
    logic       is_short;
    logic [7:0] long_code;
    logic       emit_a, emit_b;
    logic [7:0] byte_a, byte_b;
    logic       pend_mid;
    logic [3:0] held_mid;
    logic [7:0] cnt_a, cnt_b;
    ntc_res_t   res_a, res_b, res_bare;

    always_comb
    begin
        coded     = chars_taken_reg < max_chars;
        idx       = ntc_lookup(char_code);
        is_short  = idx < 6'(NTC_SHORT_CODES);
        long_code = 8'(idx) + 8'(NTC_LONG_OFFSET);

        emit_a   = 1'b0;
        byte_a   = long_code;
        pend_mid = pending_reg;
        held_mid = held_reg;
        if (coded)
        begin
            if (is_short)
            begin
                if (pending_reg)
                begin
                    emit_a   = 1'b1;
                    byte_a   = {held_reg, idx[3:0]};
                    pend_mid = 1'b0;
                    held_mid = 4'd0;
                end
                else
                begin
                    pend_mid = 1'b1;
                    held_mid = idx[3:0];
                end
            end
            else
            begin
                emit_a = 1'b1;
                if (pending_reg)
                begin
                    // long code straddles two bytes
                    byte_a   = {held_reg, long_code[7:4]};
                    held_mid = long_code[3:0];
                end
            end
        end

        // flush of an odd nibble at message end
        emit_b = msg_last & pend_mid;
        byte_b = {held_mid, 4'd0};

        cnt_a = bytes_emitted_reg + 8'd1;
        cnt_b = bytes_emitted_reg + 8'(emit_a) + 8'd1;

        res_a    = '{out_byte: byte_a, byte_valid: 1'b1, run_end: msg_last & ~emit_b,
                     bytes_so_far: cnt_a};
        res_b    = '{out_byte: byte_b, byte_valid: 1'b1, run_end: 1'b1,
                     bytes_so_far: cnt_b};
        res_bare = '{out_byte: 8'd0, byte_valid: 1'b0, run_end: 1'b1,
                     bytes_so_far: bytes_emitted_reg};

        job.two = emit_a & emit_b;
        job.r1  = res_b;
        if (emit_a)
        begin
            job.r0 = res_a;
        end
        else if (emit_b)
        begin
            job.r0 = res_b;
        end
        else
        begin
            job.r0 = res_bare;
        end
        job_valid = take & (emit_a | emit_b | msg_last);

        if (msg_last)
        begin
            pending_next       = 1'b0;
            held_next          = 4'd0;
            chars_taken_next   = 8'd0;
            bytes_emitted_next = 8'd0;
        end
        else
        begin
            pending_next       = pend_mid;
            held_next          = held_mid;
            chars_taken_next   = chars_taken_reg + 8'(coded);
            bytes_emitted_next = bytes_emitted_reg + 8'(emit_a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg       <= 1'b0;
            held_reg          <= 4'd0;
            chars_taken_reg   <= 8'd0;
            bytes_emitted_reg <= 8'd0;
        end
        else if (take)
        begin
            pending_reg       <= pending_next;
            held_reg          <= held_next;
            chars_taken_reg   <= chars_taken_next;
            bytes_emitted_reg <= bytes_emitted_next;
        end
    end

    assign status = '{nibble_pending: pending_reg, chars_taken: chars_taken_reg};

endmodule

[rtl/ntc_job_fifo.sv]
// ntc_job_fifo: short queue of result jobs between front and back end
// depends on ntc_pkg

module ntc_job_fifo #(
    parameter int unsigned DEPTH = ntc_pkg::NTC_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  ntc_pkg::ntc_job_t wr_job,
    output logic              full,
    input  logic              rd_en,
    output ntc_pkg::ntc_job_t rd_job,
    output logic              empty
);
    import ntc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ntc_job_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign do_wr = wr_en & ~full;
    assign do_rd = rd_en & ~empty;
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

[rtl/ntc_back.sv]
// ntc_back: splits queued jobs into result beats and holds the output register
// depends on ntc_pkg

module ntc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ntc_pkg::ntc_job_t head_job,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output ntc_pkg::ntc_res_t res
);
    import ntc_pkg::*;

    logic     out_valid_reg, out_valid_next;
    logic     half_reg, half_next;
    ntc_res_t res_reg;
    logic     load;

    always_comb
    begin
        load           = ~head_empty & (~out_valid_reg | pop);
        head_pop       = load & (half_reg | ~head_job.two);
        half_next      = load ? (~half_reg & head_job.two) : half_reg;
        out_valid_next = load | (out_valid_reg & ~pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= half_reg ? head_job.r1 : head_job.r0;
        end
    end

    assign empty = ~out_valid_reg;
    assign res   = res_reg;

endmodule

[rtl/nibble_text_compressor_core.sv]
// nibble_text_compressor_core: top level of the nibble text compressor
// depends on ntc_pkg, ntc_front, ntc_job_fifo, ntc_back
//
//  channel   dir   handshake                   payload
//  input     in    push / full                 char_code, msg_last
//  result    out   empty / pop                 out_byte, byte_valid, run_end, bytes_so_far
//  config    in    psel penable pwrite pready  paddr, pwdata, prdata (max_chars at 0x0)
//
// one character is taken every cycle while the job queue has room; each
// character yields zero, one or two result beats, and the output register
// gives one beat per cycle while pop is high, so the result side sets the sustained rate.
// a pushed character passes through the job queue and then the output register to the first result beat.
// rst_n clears the front state, queue pointers and output valid; max_chars resets to 80.
// full rises when the job queue is full; a held result (pop low) stalls only
// the back end until the queue fills.

module nibble_text_compressor_core #(
    parameter int unsigned QUEUE_DEPTH = ntc_pkg::NTC_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // character input
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      char_code,
    input  logic                            msg_last,
    // result output
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            run_end,
    output logic [7:0]                      bytes_so_far,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ntc_pkg::NTC_ADDR_W-1:0]  paddr,
    input  logic [ntc_pkg::NTC_DATA_W-1:0]  pwdata,
    output logic [ntc_pkg::NTC_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ntc_pkg::*;

    logic              in_take;
    logic [7:0]        max_chars_reg;
    logic              cfg_wr;
    logic              job_valid;
    ntc_job_t          job_in;
    ntc_job_t          head_job;
    logic              q_full, q_empty, q_pop;
    ntc_res_t          res;
    ntc_front_status_t front_status;

    // register file: max_chars only, word address in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == NTC_REG_MAX_CHARS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= 8'(NTC_MAX_CHARS_RESET);
        end
        else if (cfg_wr)
        begin
            max_chars_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == NTC_REG_MAX_CHARS) ? NTC_DATA_W'(max_chars_reg) : '0;

    // input beat accepted when the job queue has room
    assign full    = q_full;
    assign in_take = push & ~q_full;

    // front: lookup, nibble packing and per-message counters
    ntc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_chars (max_chars_reg),
        .take      (in_take),
        .char_code (char_code),
        .msg_last  (msg_last),
        .job_valid (job_valid),
        .job       (job_in),
        .status    (front_status)
    );

    // job queue decouples coding from result delivery
    ntc_job_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_valid),
        .wr_job (job_in),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (head_job),
        .empty  (q_empty)
    );

    // back: one result beat per cycle from the queued jobs while pop is high
    ntc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    assign out_byte     = res.out_byte;
    assign byte_valid   = res.byte_valid;
    assign run_end      = res.run_end;
    assign bytes_so_far = res.bytes_so_far;

`ifndef SYNTHESIS
    // a bare marker only ever ends a message
    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> run_end)
        else $error("bare result beat without run_end");

    // a data beat always counts itself
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_valid) |-> (bytes_so_far != 8'd0))
        else $error("data beat with zero byte count");

    // message end clears the front state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && msg_last) |=>
            (!front_status.nibble_pending && front_status.chars_taken == 8'd0))
        else $error("front state not cleared after message end");
`endif

endmodule

[dv/tb_nibble_text_compressor_core.sv]
// tb_nibble_text_compressor_core: self-checking bench for the nibble text compressor core
// depends on ntc_pkg and nibble_text_compressor_core; directed rows, then random messages
// under random push/pop gaps, each result beat checked against typed rows or a local packing predictor

module tb_nibble_text_compressor_core;

    import ntc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_PHASES = 7;
    localparam int unsigned PHASE_ITEMS   = 50;
    localparam logic [NTC_ADDR_W-1:0] CHAR_LIMIT_ADDR = NTC_ADDR_W'(4 * NTC_REG_MAX_CHARS);

    // frequency order of the code table; a duplicate space sits at index 37
    // and can never be hit since the first match wins
    string symbol_text =
        " etaoihnsrdlumwcyfgpbvkxjqz0123456789 !?.,:;()-&*\\'@#+=\243$%\"[]";

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // dut ports, all inputs driven to known values from time zero
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            char_code = 8'h00;
    logic                  msg_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic                  run_end;
    logic [7:0]            bytes_so_far;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [NTC_ADDR_W-1:0] paddr = '0;
    logic [NTC_DATA_W-1:0] pwdata = '0;
    logic [NTC_DATA_W-1:0] prdata;
    logic                  pready;

    // packing predictor state
    logic [7:0] char_limit = 8'(NTC_MAX_CHARS_RESET);
    logic       half_full = 1'b0;
    logic [3:0] half_nibble = 4'h0;
    logic [7:0] coded_count = 8'h00;
    logic [7:0] packed_count = 8'h00;

    // beats still owed by the dut, oldest first
    ntc_res_t predicted_beats [$];
    ntc_res_t want_beat;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // idling control
    bit          sender_steady = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned steady_left = 0;

    // directed stimulus table
    typedef struct {
        bit         is_limit;   // row writes max_chars instead of sending a character
        logic [7:0] value;
        logic       last;
        int         typed_n;    // -1: expectation comes from the predictor
        ntc_res_t   t0;
        ntc_res_t   t1;
    } stim_row_t;

    stim_row_t stim_rows [$];

    nibble_text_compressor_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .msg_last     (msg_last),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .run_end      (run_end),
        .bytes_so_far (bytes_so_far),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // lower-case letters only, then first match in frequency order; misses code as space
    function automatic logic [5:0] symbol_index(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
        for (int i = 0; i < symbol_text.len(); i++)
        begin
            if (8'(symbol_text[i]) == lc)
            begin
                return 6'(i);
            end
        end
        return 6'd0;
    endfunction

    function automatic ntc_res_t beat(input logic [7:0] b, input logic v, input logic e,
                                      input logic [7:0] cnt);
        ntc_res_t r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.run_end      = e;
        r.bytes_so_far = cnt;
        return r;
    endfunction

    // code one character into the nibble stream; returns how many beats it yields
    function automatic int pack_char(input logic [7:0] c, input logic last,
                                     output ntc_res_t b0, output ntc_res_t b1);
        ntc_res_t   beats [2];
        int         n;
        logic [5:0] idx;
        logic [7:0] code;
        n = 0;
        beats[0] = '0;
        beats[1] = '0;
        if (coded_count < char_limit)
        begin
            idx = symbol_index(c);
            coded_count = coded_count + 8'd1;
            if (idx < NTC_SHORT_CODES)
            begin
                if (half_full)
                begin
                    packed_count = packed_count + 8'd1;
                    beats[n] = beat({half_nibble, idx[3:0]}, 1'b1, 1'b0, packed_count);
                    n++;
                    half_full = 1'b0;
                    half_nibble = 4'h0;
                end
                else
                begin
                    half_nibble = idx[3:0];
                    half_full = 1'b1;
                end
            end
            else
            begin
                // long symbol: escape byte 0xd0..0xff, straddles bytes when a nibble is held
                code = 8'(idx + NTC_LONG_OFFSET);
                packed_count = packed_count + 8'd1;
                if (half_full)
                begin
                    beats[n] = beat({half_nibble, code[7:4]}, 1'b1, 1'b0, packed_count);
                    half_nibble = code[3:0];
                end
                else
                begin
                    beats[n] = beat(code, 1'b1, 1'b0, packed_count);
                end
                n++;
            end
        end
        if (last)
        begin
            if (half_full)
            begin
                packed_count = packed_count + 8'd1;
                beats[n] = beat({half_nibble, 4'h0}, 1'b1, 1'b0, packed_count);
                n++;
            end
            if (n == 0)
            begin
                beats[0] = beat(8'h00, 1'b0, 1'b1, packed_count);
                n = 1;
            end
            else
            begin
                beats[n-1].run_end = 1'b1;
            end
            half_full = 1'b0;
            half_nibble = 4'h0;
            coded_count = 8'h00;
            packed_count = 8'h00;
        end
        b0 = beats[0];
        b1 = beats[1];
        return n;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] pick_char(input int unsigned long_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (r < 20)
        begin
            return 8'h41 + 8'($urandom_range(0, 25));
        end
        if ($urandom_range(0, 99) < long_pct)
        begin
            return 8'(symbol_text[$urandom_range(NTC_SHORT_CODES, 60)]);
        end
        return 8'(symbol_text[$urandom_range(0, NTC_SHORT_CODES - 1)]);
    endfunction

    function automatic void row_char(input logic [7:0] c, input logic last);
        stim_row_t r;
        r.is_limit = 1'b0;
        r.value = c;
        r.last = last;
        r.typed_n = -1;
        r.t0 = '0;
        r.t1 = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_typed(input logic [7:0] c, input logic last, input int n,
                                      input ntc_res_t t0, input ntc_res_t t1);
        stim_row_t r;
        r.is_limit = 1'b0;
        r.value = c;
        r.last = last;
        r.typed_n = n;
        r.t0 = t0;
        r.t1 = t1;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_limit(input logic [7:0] v);
        stim_row_t r;
        r.is_limit = 1'b1;
        r.value = v;
        r.last = 1'b0;
        r.typed_n = -1;
        r.t0 = '0;
        r.t1 = '0;
        stim_rows.push_back(r);
    endfunction

    // offer one character beat, wait for it to be taken, then queue its results
    task automatic drive_item(input logic [7:0] c, input logic last, input int typed_n,
                              input ntc_res_t t0, input ntc_res_t t1);
        ntc_res_t    b0;
        ntc_res_t    b1;
        int          n;
        int unsigned gap;
        push <= 1'b1;
        char_code <= c;
        msg_last <= last;
        do
            @(posedge clk);
        while (full);
        n = pack_char(c, last, b0, b1);
        // hand-typed rows override the predictor but still advance its state
        if (typed_n >= 0)
        begin
            n = typed_n;
            b0 = t0;
            b1 = t1;
        end
        if (n >= 1)
        begin
            predicted_beats.push_back(b0);
        end
        if (n >= 2)
        begin
            predicted_beats.push_back(b1);
        end
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain every owed beat, then give a character that yields nothing time to land
    task automatic settle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (predicted_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of max_chars: setup cycle, then access until pready
    task automatic write_char_limit(input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CHAR_LIMIT_ADDR;
        pwdata <= NTC_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        char_limit = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_message(input int unsigned len, input int unsigned long_pct);
        for (int unsigned i = 0; i < len; i++)
        begin
            drive_item(pick_char(long_pct), i == len - 1, -1, '0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random pop with stalls, steady bursts and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (steady_left > 0)
                begin
                    steady_left--;
                end
                else if ($urandom_range(0, 49) == 0)
                begin
                    steady_left = $urandom_range(20, 60);
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // checker: every popped beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (predicted_beats.size() == 0)
            begin
                $display("%0t: unexpected beat out_byte=%h byte_valid=%b run_end=%b bytes_so_far=%0d",
                         $time, out_byte, byte_valid, run_end, bytes_so_far);
                mismatch_count++;
            end
            else
            begin
                want_beat = predicted_beats.pop_front();
                if (out_byte !== want_beat.out_byte)
                begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want_beat.out_byte, out_byte);
                    mismatch_count++;
                end
                if (byte_valid !== want_beat.byte_valid)
                begin
                    $display("%0t: byte_valid expected %b actual %b",
                             $time, want_beat.byte_valid, byte_valid);
                    mismatch_count++;
                end
                if (run_end !== want_beat.run_end)
                begin
                    $display("%0t: run_end expected %b actual %b",
                             $time, want_beat.run_end, run_end);
                    mismatch_count++;
                end
                if (bytes_so_far !== want_beat.bytes_so_far)
                begin
                    $display("%0t: bytes_so_far expected %0d actual %0d",
                             $time, want_beat.bytes_so_far, bytes_so_far);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_nibble_text_compressor_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // directed rows, max_chars at its reset value of 80 to start
        row_char ("e", 1'b0);                                        // held nibble
        row_typed("t", 1'b0, 1, beat(8'h12, 1'b1, 1'b0, 8'd1), '0);  // two short codes pack
        row_typed("A", 1'b1, 1, beat(8'h30, 1'b1, 1'b1, 8'd2), '0);  // upper case, flush at end
        row_typed(8'h00, 1'b1, 1, beat(8'h00, 1'b1, 1'b1, 8'd1), '0); // unknown byte is space
        row_typed("m", 1'b0, 1, beat(8'hd0, 1'b1, 1'b0, 8'd1), '0);  // first long code
        row_typed("]", 1'b0, 1, beat(8'hff, 1'b1, 1'b0, 8'd2), '0);  // last long code
        row_char ("e", 1'b0);
        row_typed(8'ha3, 1'b1, 2, beat(8'h1f, 1'b1, 1'b0, 8'd3),     // pound sign straddles
                  beat(8'ha0, 1'b1, 1'b1, 8'd4));
        row_char (8'hff, 1'b0);
        row_char ("Z", 1'b0);
        row_char ("u", 1'b0);
        row_char ("@", 1'b0);                                        // just below 'A'
        row_char ("[", 1'b0);                                        // just above 'Z'
        row_char ("x", 1'b1);
        // limit of one: dropped characters, then a bare end marker
        row_limit(8'd1);
        row_char ("a", 1'b0);
        row_char ("b", 1'b0);
        row_typed("c", 1'b1, 1, beat(8'h30, 1'b1, 1'b1, 8'd1), '0);
        row_typed("m", 1'b0, 1, beat(8'hd0, 1'b1, 1'b0, 8'd1), '0);
        row_typed("x", 1'b1, 1, beat(8'h00, 1'b0, 1'b1, 8'd1), '0);
        // zero limit drops everything
        row_limit(8'd0);
        row_typed("e", 1'b1, 1, beat(8'h00, 1'b0, 1'b1, 8'd0), '0);
        row_limit(8'd255);
        row_typed("9", 1'b1, 1, beat(8'he7, 1'b1, 1'b1, 8'd1), '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_limit)
            begin
                settle();
                write_char_limit(stim_rows[i].value);
            end
            else
            begin
                drive_item(stim_rows[i].value, stim_rows[i].last, stim_rows[i].typed_n,
                           stim_rows[i].t0, stim_rows[i].t1);
            end
        end

        // random messages over a spread of limits
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            int unsigned sent;
            int unsigned len;
            logic [7:0]  limit;
            case (phase)
                0: limit = 8'd255;
                1: limit = 8'd1;
                2: limit = 8'd4;
                3: limit = 8'($urandom_range(1, 255));
                4: limit = 8'd12;
                5: limit = 8'(NTC_MAX_CHARS_RESET);
                default: limit = 8'($urandom_range(2, 30));
            endcase
            settle();
            write_char_limit(limit);
            if (phase == 0)
            begin
                // one long message of mostly long codes: runs the byte count past 128
                // and the character count past the limit
                send_message(258, 85);
            end
            else
            begin
                sent = 0;
                while (sent < PHASE_ITEMS)
                begin
                    sender_steady = ($urandom_range(0, 4) == 0);
                    // pop held off while characters keep coming: fills the queue
                    if (phase == 2 && sent == 0)
                    begin
                        hold_request = 1'b1;
                        sender_steady = 1'b1;
                    end
                    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                      : $urandom_range(13, 50);
                    send_message(len, 40);
                    sent += len;
                end
                sender_steady = 1'b0;
            end
        end

        settle();
        if (mismatch_count == 0)
        begin
            $display("tb_nibble_text_compressor_core: done, clean");
        end
        else
        begin
            $display("tb_nibble_text_compressor_core: done, errors");
        end
        $finish;
    end

endmodule
